>>> hw/rtl/tmn_pkg.sv
// Package for token_mutex_node: event codes, result kinds, state encoding.
// Used by tmn_ctrl, tmn_dp and token_mutex_node.
package tmn_pkg;

  localparam int NODES = 8;

  typedef enum logic [2:0] {
    FN_LOCAL  = 3'd0,
    FN_REMOTE = 3'd1,
    FN_LN     = 3'd2,
    FN_QWORD  = 3'd3,
    FN_REL    = 3'd4,
    FN_INIT   = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_BCAST = 3'd1,
    K_HDR   = 3'd2,
    K_WORD  = 3'd3,
    K_GRANT = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_HDR,
    S_LN,
    S_QUE,
    S_OUT
  } state_e;

  localparam logic signed [15:0] NoneYet = -16'sd1;
  localparam logic signed [15:0] SeqMax  = 16'sd32767;

  // controller to datapath
  typedef struct packed {
    logic exec;      // apply the captured event's simple updates
    logic scan_step; // examine scan index for release enqueue
    logic pop_dest;  // release: take queue head as destination
    logic emit_hdr;
    logic emit_ln;
    logic emit_q;
    logic fin_send;  // clear queue after stream
    logic out_take;  // output register consumed
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_send;   // exec decided to send token
    logic go_scan;   // exec decided on release scan
    logic scan_done;
    logic has_queue; // queue nonempty after scan
    logic ln_done;
    logic q_done;
    logic out_full;
  } sts_t;

endpackage

>>> hw/rtl/tmn_ctrl.sv
// Controller FSM for token_mutex_node.
// Depends on tmn_pkg; drives tmn_dp through cmd_t, reads sts_t.
module tmn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tmn_pkg::sts_t sts_i,
  output tmn_pkg::cmd_t cmd_o
);
  import tmn_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = !sts_i.out_full;
        if (in_valid_i && !sts_i.out_full) state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.go_send) state_d = S_HDR;
        else if (sts_i.go_scan) state_d = S_SCAN;
        else state_d = S_OUT;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.has_queue) begin
            cmd_o.pop_dest = 1'b1;
            state_d = S_HDR;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_HDR: begin
        if (!sts_i.out_full) begin
          cmd_o.emit_hdr = 1'b1;
          state_d = S_LN;
        end
      end
      S_LN: begin
        if (!sts_i.out_full) begin
          cmd_o.emit_ln = 1'b1;
          if (sts_i.ln_done) state_d = S_QUE;
        end
      end
      S_QUE: begin
        if (sts_i.q_done) begin
          cmd_o.fin_send = 1'b1;
          state_d = S_OUT;
        end else if (!sts_i.out_full) begin
          cmd_o.emit_q = 1'b1;
        end
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  a_exec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> !cmd_o.exec) else $error("exec repeated");
  a_hdr_then_ln: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_hdr |=> state_q == S_LN) else $error("header not followed by LN");
endmodule

>>> hw/rtl/tmn_dp.sv
// Datapath for token_mutex_node: node tables, token queue, output register.
// Depends on tmn_pkg; controlled by tmn_ctrl.
module tmn_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  logic [2:0]         func_i,
  input  logic [2:0]         peer_i,
  input  logic signed [15:0] seq_i,
  input  logic               last_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  input  tmn_pkg::cmd_t      cmd_i,
  output tmn_pkg::sts_t      sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [2:0]         kind_o,
  output logic [2:0]         node_o,
  output logic signed [15:0] value_o,
  output logic               queued_o,
  output logic               last_res_o
);
  import tmn_pkg::*;

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = $clog2(NODES + 1);

  logic [2:0]         self_cfg_q;
  logic [2:0]         func_q, peer_q;
  logic signed [15:0] seq_q;
  logic               last_q;
  logic signed [15:0] rn_q [NODES];
  logic signed [15:0] ln_q [NODES];
  logic [2:0]         wq_q [NODES];
  logic [IW-1:0]      head_q;
  logic [CW-1:0]      cnt_q;
  logic               hold_q, req_q;
  logic [IW-1:0]      idx_q;
  logic [CW-1:0]      k_q;
  logic [2:0]         dest_q;
  logic [CW-1:0]      scnt_q;
  logic               ov_q;
  logic [2:0]         kind_q, node_q;
  logic signed [15:0] val_q;
  logic               qd_q, lr_q;

  logic [2:0] self_w;
  logic       peer_ok, peer_self;
  logic [IW-1:0] pidx, sidx;
  logic signed [15:0] rn_new;
  logic [CW-1:0] ndup;

  assign self_w = (32'(self_cfg_q) < NODES) ? self_cfg_q : 3'(NODES - 1);
  assign sidx   = IW'(self_w);
  assign peer_ok = 32'(peer_q) < NODES;
  assign pidx   = IW'(peer_q);
  assign peer_self = peer_q == self_w;
  assign rn_new = (seq_q > rn_q[pidx]) ? seq_q : rn_q[pidx];

  // membership test of queue
  function automatic logic q_has(input logic [2:0] id,
      input logic [2:0] wq [NODES], input logic [IW-1:0] hd, input logic [CW-1:0] c);
    logic r;
    logic [IW-1:0] s;
    r = 1'b0;
    for (int k = 0; k < NODES; k++) begin
      s = IW'((32'(hd) + k) % NODES);
      if (k < 32'(c) && wq[s] == id) r = 1'b1;
    end
    return r;
  endfunction

  logic push_en;
  logic [2:0] push_id;
  logic ok_push;
  logic [IW-1:0] tail;
  assign tail = IW'((32'(head_q) + 32'(cnt_q)) % NODES);
  assign ok_push = push_en && 32'(push_id) < NODES && push_id != self_w &&
                   32'(cnt_q) < NODES && !q_has(push_id, wq_q, head_q, cnt_q);

  always_comb begin
    ndup = '0;
    for (int k = 0; k < NODES; k++)
      if (k < 32'(cnt_q) && wq_q[IW'((32'(head_q) + k) % NODES)] != peer_q)
        ndup = ndup + CW'(1);
  end

  logic go_send, go_scan;
  always_comb begin
    go_send = 1'b0;
    go_scan = 1'b0;
    if (func_q == FN_REMOTE && peer_ok && !peer_self && hold_q && !req_q &&
        rn_new == ln_q[pidx] + 16'sd1) go_send = 1'b1;
    if (func_q == FN_REL && hold_q) go_scan = 1'b1;
  end

  logic scan_hit;
  assign scan_hit = idx_q != sidx && rn_q[idx_q] == ln_q[idx_q] + 16'sd1;
  assign push_en  = (cmd_i.exec && func_q == FN_QWORD && !hold_q) ||
                    (cmd_i.scan_step && scan_hit);
  assign push_id  = cmd_i.scan_step ? 3'(idx_q) : peer_q;

  logic [IW-1:0] qslot;
  assign qslot = IW'((32'(head_q) + 32'(k_q)) % NODES);

  assign sts_o.go_send   = go_send;
  assign sts_o.go_scan   = go_scan;
  assign sts_o.scan_done = 32'(idx_q) == NODES - 1;
  assign sts_o.has_queue = (cnt_q != '0) || ok_push;
  assign sts_o.ln_done   = 32'(idx_q) == NODES - 1;
  assign sts_o.q_done    = k_q == cnt_q;
  assign sts_o.out_full  = ov_q;

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      func_q <= func_i; peer_q <= peer_i; seq_q <= seq_i; last_q <= last_i;
    end
    if (go_send && cmd_i.exec) dest_q <= peer_q;
    if (cmd_i.pop_dest) dest_q <= (cnt_q != '0) ? wq_q[head_q] : push_id;
    if (ok_push) wq_q[tail] <= push_id;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_cfg_q <= '0;
      for (int i = 0; i < NODES; i++) begin
        rn_q[i] <= NoneYet; ln_q[i] <= NoneYet;
      end
      head_q <= '0; cnt_q <= '0; hold_q <= 1'b0; req_q <= 1'b0;
      idx_q <= '0; k_q <= '0; scnt_q <= '0; ov_q <= 1'b0;
      kind_q <= '0; node_q <= '0; val_q <= '0; qd_q <= 1'b0; lr_q <= 1'b0;
    end else begin
      if (cfg_we_i) self_cfg_q <= cfg_wdata_i;
      if (cmd_i.out_take || (ov_q && out_ready_i)) ov_q <= 1'b0;
      if (ok_push) cnt_q <= cnt_q + CW'(1);
      if (cmd_i.exec) begin
        idx_q <= '0;
        k_q   <= '0;
        if (go_send) scnt_q <= ndup;
        unique case (func_q)
          FN_LOCAL: begin
            if (hold_q) begin
              req_q <= 1'b1;
              ov_q <= 1'b1; kind_q <= K_GRANT; node_q <= self_w;
              val_q <= rn_q[sidx]; qd_q <= 1'b0; lr_q <= 1'b1;
            end else if (!req_q) begin
              req_q <= 1'b1;
              if (rn_q[sidx] < SeqMax) rn_q[sidx] <= rn_q[sidx] + 16'sd1;
              ov_q <= 1'b1; kind_q <= K_BCAST; node_q <= self_w;
              val_q <= (rn_q[sidx] < SeqMax) ? rn_q[sidx] + 16'sd1 : rn_q[sidx];
              qd_q <= 1'b0; lr_q <= 1'b1;
            end
          end
          FN_REMOTE: begin
            if (peer_ok && !peer_self) rn_q[pidx] <= rn_new;
          end
          FN_LN, FN_QWORD: begin
            if (!hold_q) begin
              if (func_q == FN_LN && peer_ok) ln_q[pidx] <= seq_q;
              if (last_q) begin
                hold_q <= 1'b1;
                if (req_q) begin
                  ov_q <= 1'b1; kind_q <= K_GRANT; node_q <= self_w;
                  val_q <= rn_q[sidx]; qd_q <= 1'b0; lr_q <= 1'b1;
                end
              end
            end
          end
          FN_REL: begin
            if (hold_q) begin
              ln_q[sidx] <= rn_q[sidx];
              req_q <= 1'b0;
            end
          end
          FN_INIT: begin
            for (int i = 0; i < NODES; i++) begin
              rn_q[i] <= NoneYet; ln_q[i] <= NoneYet;
            end
            head_q <= '0; cnt_q <= '0; req_q <= 1'b0;
            hold_q <= self_w == 3'd0;
          end
          default: ;
        endcase
      end
      if (cmd_i.scan_step) idx_q <= idx_q + IW'(1);
      if (cmd_i.pop_dest) begin
        idx_q  <= '0;
        head_q <= IW'((32'(head_q) + 1) % NODES);
        cnt_q  <= cnt_q + CW'(ok_push) - CW'(1);
        scnt_q <= cnt_q + CW'(ok_push) - CW'(1);
      end
      if (cmd_i.emit_hdr) begin
        hold_q <= 1'b0;
        idx_q  <= '0;
        ov_q <= 1'b1; kind_q <= K_HDR; node_q <= dest_q;
        val_q <= 16'(scnt_q); qd_q <= 1'b0; lr_q <= 1'b0;
      end
      if (cmd_i.emit_ln) begin
        idx_q <= idx_q + IW'(1);
        ov_q <= 1'b1; kind_q <= K_WORD; node_q <= 3'(idx_q);
        val_q <= ln_q[idx_q]; qd_q <= 1'b0;
        lr_q <= sts_o.ln_done && scnt_q == '0;
      end
      if (cmd_i.emit_q) begin
        k_q <= k_q + CW'(1);
        if (wq_q[qslot] != dest_q) begin
          scnt_q <= scnt_q - CW'(1);
          ov_q <= 1'b1; kind_q <= K_WORD; node_q <= wq_q[qslot];
          val_q <= '0; qd_q <= 1'b1; lr_q <= scnt_q == CW'(1);
        end
      end
      if (cmd_i.fin_send) begin
        head_q <= '0; cnt_q <= '0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign kind_o      = kind_q;
  assign node_o      = node_q;
  assign value_o     = val_q;
  assign queued_o    = qd_q;
  assign last_res_o  = lr_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= NODES) else $error("queue count overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(val_q)) else $error("result lost");
  a_hdr_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_hdr |=> !hold_q) else $error("token kept after send");
endmodule

>>> hw/rtl/token_mutex_node.sv
// token_mutex_node: one node of Suzuki-Kasami token mutual exclusion.
// Top level; instantiates tmn_ctrl and tmn_dp, uses tmn_pkg.
//
// Input channel (in_valid_i/in_ready_o) carries one event request: func_i,
// peer_i, seq_i, last_i. Output channel (out_valid_o/out_ready_i) carries
// result words kind_o, node_o, value_o, queued_o, last_res_o; last_res_o
// marks the final word of one event. Events with nothing to report give
// no word. self_id is to be written through cfg_we_i/cfg_wdata_i only while
// idle; the block itself does not enforce this. A simple event is applied in
// the EXEC state and its result is registered in the output register. A token
// send emits a header, NODES LN words, then the queue entries; the next word
// waits until the output register is free. A release first scans the NODES
// node entries, one node entry per cycle.
// One event is in work at a time; the next is accepted once the state
// machine returns to idle and the output register is free.
// Reset clears the RN and LN tables to -1, empties the queue and drops the
// token; an init event does the same and gives the token to node 0. A stalled
// receiver holds the output register and the stream pauses until it is taken.
module token_mutex_node (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         func_i,
  input  logic [2:0]         peer_i,
  input  logic signed [15:0] seq_i,
  input  logic               last_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         kind_o,
  output logic [2:0]         node_o,
  output logic signed [15:0] value_o,
  output logic               queued_o,
  output logic               last_res_o
);
  import tmn_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic fire;

  assign fire = in_valid_i && in_ready_o;

  tmn_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sts_i(sts), .cmd_o(cmd)
  );

  tmn_dp u_dp (
    .clk_i, .rst_ni, .in_fire_i(fire), .func_i, .peer_i, .seq_i, .last_i,
    .cfg_we_i, .cfg_wdata_i, .cmd_i(cmd), .sts_o(sts), .out_ready_i,
    .out_valid_o, .kind_o, .node_o, .value_o, .queued_o, .last_res_o
  );
endmodule
